// ===== src/hpcs_pkg.sv =====
`default_nettype none
package hpcs_pkg;
   typedef enum logic [2:0] {
      OP_REQUEST    = 3'd0,
      OP_OUTCOME    = 3'd1,
      OP_TICK       = 3'd2,
      OP_CONNECT    = 3'd3,
      OP_DISCONNECT = 3'd4
   } op_type;

   localparam logic [1:0] KIND_SUBMIT   = 2'd0;
   localparam logic [1:0] KIND_DONE     = 2'd1;
   localparam logic [1:0] KIND_DEFER    = 2'd2;
   localparam logic [1:0] KIND_REMOVED  = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_STALL   = 3'd1;
   localparam logic [2:0] ST_IOERR   = 3'd2;
   localparam logic [2:0] ST_RESET   = 3'd3;
   localparam logic [2:0] ST_NOCHAN  = 3'd4;
   localparam logic [2:0] ST_UNSUPP  = 3'd5;
   localparam logic [2:0] ST_CTRL    = 3'd6;

   // channel outcome codes
   localparam logic [2:0] RES_IDLE  = 3'd0;
   localparam logic [2:0] RES_DONE  = 3'd1;
   localparam logic [2:0] RES_NAK   = 3'd2;
   localparam logic [2:0] RES_NYET  = 3'd3;
   localparam logic [2:0] RES_ERROR = 3'd4;
   localparam logic [2:0] RES_HALT  = 3'd5;

   localparam logic [7:0]  EP_CTRL_OUT    = 8'h00;
   localparam logic [7:0]  EP_CTRL_IN     = 8'h80;
   localparam logic [1:0]  TYPE_BULK      = 2'd2;
   localparam logic [1:0]  TYPE_INTR      = 2'd3;
   localparam logic [15:0] FALLBACK_RESET = 16'd8;

   // one classified request travelling front to back
   typedef struct packed {
      op_type      op;
      logic [6:0]  dev_addr;
      logic [7:0]  ep_addr;
      logic        type_ok;
      logic [15:0] poll_interval;
      logic [7:0]  xfer_tag;
      logic [3:0]  channel;
      logic [2:0]  result_code;
      logic [15:0] bytes_min;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  channel_res;
      logic [2:0]  status;
      logic [7:0]  xfer_tag;
      logic [7:0]  ep_addr;
      logic [6:0]  dev_addr;
      logic        reinit;
      logic [15:0] bytes_added;
      logic        last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/hpcs_front.sv =====
`default_nettype none
module hpcs_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic [2:0]      req_op,
   input  wire logic [6:0]      req_dev_addr,
   input  wire logic [7:0]      req_ep_addr,
   input  wire logic [1:0]      req_ep_type,
   input  wire logic [15:0]     req_poll_interval,
   input  wire logic [7:0]      req_xfer_tag,
   input  wire logic [3:0]      req_channel,
   input  wire logic [2:0]      req_result_code,
   input  wire logic [15:0]     req_byte_count,
   input  wire logic [15:0]     req_buffer_room,
   output logic                 cmd_valid,
   input  wire logic            cmd_ready,
   output hpcs_pkg::cmd_type    cmd_data
);
   import hpcs_pkg::*;

   // two-entry queue of classified requests
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push, pop;

   always_comb begin
      cls.op            = op_type'(req_op);
      cls.dev_addr      = req_dev_addr;
      cls.ep_addr       = req_ep_addr;
      cls.type_ok       = (req_ep_type == TYPE_BULK) || (req_ep_type == TYPE_INTR);
      cls.poll_interval = req_poll_interval;
      cls.xfer_tag      = req_xfer_tag;
      cls.channel       = req_channel;
      cls.result_code   = req_result_code;
      cls.bytes_min     = (req_byte_count < req_buffer_room) ? req_byte_count
                                                              : req_buffer_room;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[0];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         if (pop) begin
            // push and pop together only with one entry held
            q_in[cnt_ff[1]] = cls;
         end else begin
            q_in[cnt_ff[0]] = cls;
         end
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/hpcs_back.sv =====
`default_nettype none
module hpcs_back #(
   parameter int NUM_CHANNELS       = 16,
   parameter int FIRST_PIPE_CHANNEL = 2
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic [15:0]     fallback,
   input  wire logic            cmd_valid,
   output logic                 cmd_ready,
   input  wire hpcs_pkg::cmd_type cmd_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output hpcs_pkg::rsp_type    rsp_data
);
   import hpcs_pkg::*;

   localparam logic [3:0] FIRST = 4'(FIRST_PIPE_CHANNEL);
   localparam logic [3:0] LASTC = 4'(NUM_CHANNELS - 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_CLAIM = 5'b00100,
      S_ONE   = 5'b01000,
      S_FINAL = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [3:0] ch_ff, ch_in;
   logic [3:0] free_ff, free_in;
   logic       free_ok_ff, free_ok_in;
   logic       conn_ff, conn_in;
   logic [31:0] now_ff, now_in;

   logic [NUM_CHANNELS-1:0] own_ff, own_in, busy_ff, busy_in;
   logic [7:0]  tag_ff [NUM_CHANNELS];
   logic [7:0]  tag_in [NUM_CHANNELS];
   logic [7:0]  ep_ff  [NUM_CHANNELS];
   logic [7:0]  ep_in  [NUM_CHANNELS];
   logic [6:0]  dv_ff  [NUM_CHANNELS];
   logic [6:0]  dv_in  [NUM_CHANNELS];
   logic [15:0] iv_ff  [NUM_CHANNELS];
   logic [15:0] iv_in  [NUM_CHANNELS];
   logic [31:0] due_ff [NUM_CHANNELS];
   logic [31:0] due_in [NUM_CHANNELS];

   // output register; a pending result stalls the scan
   logic    ov_ff, ov_in;
   rsp_type od_ff, od_in;
   logic    emit;
   rsp_type em;
   logic    hold;
   logic    pend_ff, pend_in; // a result already emitted during this request

   logic [31:0] diff;
   logic [3:0]  oc;
   logic [15:0] ivl;

   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;
   assign cmd_ready = (state_ff == S_IDLE);
   assign hold      = ov_ff && !rsp_ready;
   assign diff      = now_ff - due_ff[ch_ff];
   assign oc        = cmd_ff.channel;
   assign ivl       = (iv_ff[oc] == 16'd0) ? fallback : iv_ff[oc];

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; ch_in = ch_ff;
      free_in = free_ff; free_ok_in = free_ok_ff; conn_in = conn_ff;
      now_in = now_ff; own_in = own_ff; busy_in = busy_ff;
      tag_in = tag_ff; ep_in = ep_ff; dv_in = dv_ff; iv_in = iv_ff;
      due_in = due_ff; pend_in = pend_ff;
      emit = 1'b0; em = '0;
      ov_in = ov_ff && !rsp_ready; od_in = od_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in = cmd_data; ch_in = FIRST; free_ok_in = 1'b0;
               pend_in = 1'b0; state_in = S_IDLE;
               unique case (cmd_data.op)
                  OP_REQUEST:    state_in = S_ONE;
                  OP_OUTCOME:    state_in = S_ONE;
                  OP_TICK: begin
                     now_in = now_ff + 32'd1;
                     if (conn_ff) state_in = S_SCAN;
                  end
                  OP_CONNECT:    conn_in = 1'b1;
                  OP_DISCONNECT: if (conn_ff) state_in = S_SCAN;
                  default: ;
               endcase
               if (cmd_data.op == OP_REQUEST && conn_ff &&
                   cmd_data.ep_addr != EP_CTRL_OUT && cmd_data.ep_addr != EP_CTRL_IN &&
                   cmd_data.type_ok) begin
                  state_in = S_SCAN;
               end
            end
         end
         // one channel per cycle, paused while a result waits untaken in the output register
         S_SCAN: if (!hold) begin
            unique case (cmd_ff.op)
               OP_REQUEST: begin
                  if (own_ff[ch_ff] && ep_ff[ch_ff] == cmd_ff.ep_addr &&
                      dv_ff[ch_ff] == cmd_ff.dev_addr) begin
                     emit = 1'b1; em.kind = KIND_DEFER; em.channel_res = ch_ff;
                     em.xfer_tag = cmd_ff.xfer_tag; em.last = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     if (!own_ff[ch_ff] && !free_ok_ff) begin
                        free_in = ch_ff; free_ok_in = 1'b1;
                     end
                     if (ch_ff == LASTC) state_in = S_CLAIM;
                     ch_in = ch_ff + 4'd1;
                  end
               end
               OP_TICK: begin
                  if (own_ff[ch_ff] && !busy_ff[ch_ff] && !diff[31]) begin
                     busy_in[ch_ff] = 1'b1;
                     emit = 1'b1; em.kind = KIND_SUBMIT; em.channel_res = ch_ff;
                     em.xfer_tag = tag_ff[ch_ff]; em.ep_addr = ep_ff[ch_ff];
                     em.dev_addr = dv_ff[ch_ff]; pend_in = 1'b1;
                  end
                  if (ch_ff == LASTC) begin
                     state_in = S_FINAL;
                  end
                  ch_in = ch_ff + 4'd1;
               end
               default: begin // disconnect
                  if (own_ff[ch_ff]) begin
                     own_in[ch_ff] = 1'b0;
                     emit = 1'b1; em.kind = KIND_DONE; em.channel_res = ch_ff;
                     em.status = ST_RESET; em.xfer_tag = tag_ff[ch_ff];
                  end
                  busy_in[ch_ff] = 1'b0; ep_in[ch_ff] = '0; dv_in[ch_ff] = '0;
                  due_in[ch_ff] = '0;
                  if (ch_ff == LASTC) state_in = S_FINAL;
                  ch_in = ch_ff + 4'd1;
               end
            endcase
         end
         S_CLAIM: if (!hold) begin
            emit = 1'b1; em.xfer_tag = cmd_ff.xfer_tag; em.last = 1'b1;
            if (free_ok_ff) begin
               em.kind = KIND_SUBMIT; em.channel_res = free_ff;
               em.ep_addr = cmd_ff.ep_addr; em.dev_addr = cmd_ff.dev_addr;
               em.reinit = (ep_ff[free_ff] != cmd_ff.ep_addr) ||
                           (dv_ff[free_ff] != cmd_ff.dev_addr);
               if (em.reinit) begin
                  ep_in[free_ff] = cmd_ff.ep_addr; dv_in[free_ff] = cmd_ff.dev_addr;
                  due_in[free_ff] = '0;
               end
               own_in[free_ff] = 1'b1; busy_in[free_ff] = 1'b1;
               tag_in[free_ff] = cmd_ff.xfer_tag; iv_in[free_ff] = cmd_ff.poll_interval;
            end else begin
               em.kind = KIND_DONE; em.status = ST_NOCHAN;
            end
            state_in = S_IDLE;
         end
         S_ONE: if (!hold) begin
            state_in = S_IDLE;
            if (cmd_ff.op == OP_REQUEST) begin
               emit = 1'b1; em.kind = KIND_DONE; em.xfer_tag = cmd_ff.xfer_tag;
               em.last = 1'b1;
               priority if (!conn_ff) em.status = ST_RESET;
               else if (cmd_ff.ep_addr == EP_CTRL_OUT || cmd_ff.ep_addr == EP_CTRL_IN)
                  em.status = ST_CTRL;
               else em.status = ST_UNSUPP;
            end else if (oc >= FIRST && {1'b0, oc} < 5'(NUM_CHANNELS) &&
                         own_ff[oc] && busy_ff[oc] && cmd_ff.result_code != RES_IDLE) begin
               busy_in[oc] = 1'b0;
               if (cmd_ff.result_code == RES_NAK || cmd_ff.result_code == RES_NYET) begin
                  due_in[oc] = now_ff + {16'd0, ivl};
               end else begin
                  own_in[oc] = 1'b0;
                  emit = 1'b1; em.kind = KIND_DONE; em.channel_res = oc;
                  em.xfer_tag = tag_ff[oc]; em.last = 1'b1;
                  priority if (cmd_ff.result_code == RES_DONE) begin
                     em.status = ST_OK;
                     if (ep_ff[oc][7]) em.bytes_added = cmd_ff.bytes_min;
                  end else if (cmd_ff.result_code == RES_HALT) em.status = ST_STALL;
                  else em.status = ST_IOERR;
               end
            end
         end
         S_FINAL: if (!hold) begin
            state_in = S_IDLE;
            if (cmd_ff.op == OP_DISCONNECT) begin
               conn_in = 1'b0;
               emit = 1'b1; em.kind = KIND_REMOVED; em.last = 1'b1;
            end else if (pend_ff) begin
               // re-issue the held last submit with its last flag: handled by
               // flagging the register copy below
               ov_in = ov_ff && !rsp_ready;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (emit) begin
         ov_in = 1'b1; od_in = em;
      end
   end

   // Tick results: the last one found must carry the last flag. The scan
   // keeps the most recent submit in a staging slot and only forwards it
   // when the next one is found or the scan ends.
   rsp_type stg_ff, stg_in;
   logic    stg_v_ff, stg_v_in;
   logic    ov_q, ov_fin;
   rsp_type od_fin;
   logic    stage_mode;

   assign stage_mode = (cmd_ff.op == OP_TICK) && (state_ff == S_SCAN || state_ff == S_FINAL);

   always_comb begin
      stg_in = stg_ff; stg_v_in = stg_v_ff;
      ov_fin = ov_in; od_fin = od_in; ov_q = ov_ff && !rsp_ready;
      if (stage_mode && !hold) begin
         ov_fin = ov_q; od_fin = od_ff;
         if (emit) begin
            if (stg_v_ff) begin
               ov_fin = 1'b1; od_fin = stg_ff;
            end
            stg_in = em; stg_v_in = 1'b1;
         end
         if (state_ff == S_FINAL) begin
            if (stg_v_ff) begin
               ov_fin = 1'b1; od_fin = stg_ff; od_fin.last = 1'b1;
            end
            stg_v_in = 1'b0;
         end
      end
      if (state_ff == S_IDLE) stg_v_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; ch_ff <= ch_in; free_ff <= free_in;
      tag_ff <= tag_in; iv_ff <= iv_in; od_ff <= od_fin; stg_ff <= stg_in;
      if (reset) begin
         state_ff <= S_IDLE; free_ok_ff <= 1'b0; conn_ff <= 1'b0; now_ff <= '0;
         own_ff <= '0; busy_ff <= '0; ov_ff <= 1'b0; pend_ff <= 1'b0;
         stg_v_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            ep_ff[i] <= '0; dv_ff[i] <= '0; due_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; free_ok_ff <= free_ok_in; conn_ff <= conn_in;
         now_ff <= now_in; own_ff <= own_in; busy_ff <= busy_in;
         ov_ff <= ov_fin; pend_ff <= pend_in; stg_v_ff <= stg_v_in;
         ep_ff <= ep_in; dv_ff <= dv_in; due_ff <= due_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/host_pipe_channel_scheduler.sv =====
`default_nettype none
// Host pipe channel scheduler. Requests (transfer requests, channel
// outcomes, millisecond ticks, connect and disconnect) are classified by a
// front stage into a two-entry queue; a back stage carries them out over
// the per-channel state one channel per cycle. Accepted transfer requests,
// ticks and disconnects scan channels FIRST_PIPE_CHANNEL to NUM_CHANNELS-1
// while the port is connected, a request stopping early on a deferral;
// outcomes and refused requests pass through S_ONE, connect stays idle. The
// back-stage scan loop sets the rate; results wait in an output register
// and the scan pauses while it is full. fallback_interval_ms resets to 8.
module host_pipe_channel_scheduler #(
   parameter int NUM_CHANNELS       = 16,
   parameter int FIRST_PIPE_CHANNEL = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_fallback_interval_ms,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_op,
   input  wire logic [6:0]  req_dev_addr,
   input  wire logic [7:0]  req_ep_addr,
   input  wire logic [1:0]  req_ep_type,
   input  wire logic [15:0] req_poll_interval,
   input  wire logic [7:0]  req_xfer_tag,
   input  wire logic [3:0]  req_channel,
   input  wire logic [2:0]  req_result_code,
   input  wire logic [15:0] req_byte_count,
   input  wire logic [15:0] req_buffer_room,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [3:0]       rsp_channel_res,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_out_xfer_tag,
   output logic [7:0]       rsp_out_ep_addr,
   output logic [6:0]       rsp_out_dev_addr,
   output logic             rsp_reinit,
   output logic [15:0]      rsp_bytes_added,
   output logic             rsp_last
);
   import hpcs_pkg::*;

   logic [15:0] fallback_ff;
   logic        cmd_valid, cmd_ready;
   cmd_type     cmd_data;
   rsp_type     rsp_data;

   // fallback retry interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= FALLBACK_RESET;
      end else if (csr_write) begin
         fallback_ff <= csr_fallback_interval_ms;
      end
   end

   hpcs_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_dev_addr,
      .req_ep_addr, .req_ep_type, .req_poll_interval, .req_xfer_tag,
      .req_channel, .req_result_code, .req_byte_count, .req_buffer_room,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   hpcs_back #(
      .NUM_CHANNELS(NUM_CHANNELS), .FIRST_PIPE_CHANNEL(FIRST_PIPE_CHANNEL)
   ) u_back (
      .clock, .reset, .fallback(fallback_ff), .cmd_valid, .cmd_ready,
      .cmd_data, .rsp_valid, .rsp_ready, .rsp_data
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_channel_res  = rsp_data.channel_res;
   assign rsp_status       = rsp_data.status;
   assign rsp_out_xfer_tag = rsp_data.xfer_tag;
   assign rsp_out_ep_addr  = rsp_data.ep_addr;
   assign rsp_out_dev_addr = rsp_data.dev_addr;
   assign rsp_reinit       = rsp_data.reinit;
   assign rsp_bytes_added  = rsp_data.bytes_added;
   assign rsp_last         = rsp_data.last;
endmodule
`default_nettype wire

// ===== tb/tb_host_pipe_channel_scheduler.sv =====
`timescale 1ns / 1ps
module tb_host_pipe_channel_scheduler;
   import hpcs_pkg::*;

   localparam int NUM_CH   = 16;
   localparam int FIRST_CH = 2;
   // back-stage time for up to three queued requests that yield no response
   localparam int SETTLE_CYCLES = 64;

   localparam logic [1:0] TYPE_CTRL      = 2'd0;
   localparam logic [1:0] TYPE_ISO       = 2'd1;
   localparam logic [2:0] RES_UNKNOWN    = 3'd7;
   localparam logic [2:0] OP_UNKNOWN_LO  = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_HI  = 3'd7;

   // one request as presented on the req_ channel
   typedef struct packed {
      logic [2:0]  op;
      logic [6:0]  dev;
      logic [7:0]  ep;
      logic [1:0]  ept;
      logic [15:0] ivl;
      logic [7:0]  tag;
      logic [3:0]  ch;
      logic [2:0]  res;
      logic [15:0] cnt;
      logic [15:0] room;
   } sched_req_type;

   // directed row; fixed_rsp is used instead of the predictor when fixed is set
   typedef struct {
      sched_req_type item;
      bit            fixed;
      rsp_type       fixed_rsp;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [15:0] csr_fallback_interval_ms = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [6:0]  req_dev_addr = '0;
   logic [7:0]  req_ep_addr = '0;
   logic [1:0]  req_ep_type = '0;
   logic [15:0] req_poll_interval = '0;
   logic [7:0]  req_xfer_tag = '0;
   logic [3:0]  req_channel = '0;
   logic [2:0]  req_result_code = '0;
   logic [15:0] req_byte_count = '0;
   logic [15:0] req_buffer_room = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_channel_res;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_out_xfer_tag;
   logic [7:0]  rsp_out_ep_addr;
   logic [6:0]  rsp_out_dev_addr;
   logic        rsp_reinit;
   logic [15:0] rsp_bytes_added;
   logic        rsp_last;

   host_pipe_channel_scheduler uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_fallback_interval_ms(csr_fallback_interval_ms),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_dev_addr(req_dev_addr), .req_ep_addr(req_ep_addr),
      .req_ep_type(req_ep_type), .req_poll_interval(req_poll_interval),
      .req_xfer_tag(req_xfer_tag), .req_channel(req_channel),
      .req_result_code(req_result_code), .req_byte_count(req_byte_count),
      .req_buffer_room(req_buffer_room),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_channel_res(rsp_channel_res), .rsp_status(rsp_status),
      .rsp_out_xfer_tag(rsp_out_xfer_tag), .rsp_out_ep_addr(rsp_out_ep_addr),
      .rsp_out_dev_addr(rsp_out_dev_addr), .rsp_reinit(rsp_reinit),
      .rsp_bytes_added(rsp_bytes_added), .rsp_last(rsp_last)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor: shadow copy of the channel table, port state and ms counter
   // ---------------------------------------------------------------------
   logic        ch_owned [NUM_CH];
   logic        ch_busy  [NUM_CH];
   logic [7:0]  ch_tag   [NUM_CH];
   logic [7:0]  ch_ep    [NUM_CH];
   logic [6:0]  ch_dev   [NUM_CH];
   logic [15:0] ch_ivl   [NUM_CH];
   logic [31:0] ch_due   [NUM_CH];
   logic        port_up;
   logic [31:0] ms_now;
   logic [15:0] fallback_ms;

   rsp_type step_rsps[$];    // responses caused by the request in hand
   rsp_type pending_rsps[$]; // responses still owed by the block
   int      errors = 0;

   // idling knobs, in percent; hold_left is a long receiver hold-off
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;

   function automatic void add_rsp(logic [1:0] k, logic [3:0] c, logic [2:0] s,
                                   logic [7:0] t, logic [7:0] e, logic [6:0] d,
                                   logic ri, logic [15:0] b);
      rsp_type x;
      x.kind = k; x.channel_res = c; x.status = s; x.xfer_tag = t;
      x.ep_addr = e; x.dev_addr = d; x.reinit = ri; x.bytes_added = b;
      x.last = 1'b0;
      step_rsps.push_back(x);
   endfunction

   function automatic void sched_predict(sched_req_type r);
      bit          found;
      logic        re;
      logic [15:0] iv;
      logic [31:0] diff;
      logic [2:0]  st;
      step_rsps.delete();
      found = 0;
      case (r.op)
         OP_REQUEST: begin
            if (!port_up)
               add_rsp(KIND_DONE, 0, ST_RESET, r.tag, 0, 0, 0, 0);
            else if (r.ep == EP_CTRL_OUT || r.ep == EP_CTRL_IN)
               add_rsp(KIND_DONE, 0, ST_CTRL, r.tag, 0, 0, 0, 0);
            else if (r.ept != TYPE_BULK && r.ept != TYPE_INTR)
               add_rsp(KIND_DONE, 0, ST_UNSUPP, r.tag, 0, 0, 0, 0);
            else begin
               // same device and endpoint already on a channel: defer
               for (int c = FIRST_CH; c < NUM_CH; c++)
                  if (!found && ch_owned[c] && ch_ep[c] == r.ep && ch_dev[c] == r.dev) begin
                     add_rsp(KIND_DEFER, 4'(c), ST_OK, r.tag, 0, 0, 0, 0);
                     found = 1;
                  end
               // lowest free channel; toggle reset only on a new endpoint
               for (int c = FIRST_CH; c < NUM_CH; c++)
                  if (!found && !ch_owned[c]) begin
                     re = (ch_ep[c] != r.ep || ch_dev[c] != r.dev);
                     if (re) begin
                        ch_ep[c] = r.ep; ch_dev[c] = r.dev; ch_due[c] = '0;
                     end
                     ch_owned[c] = 1; ch_tag[c] = r.tag; ch_ivl[c] = r.ivl;
                     ch_busy[c] = 1;
                     add_rsp(KIND_SUBMIT, 4'(c), ST_OK, r.tag, r.ep, r.dev, re, 0);
                     found = 1;
                  end
               if (!found)
                  add_rsp(KIND_DONE, 0, ST_NOCHAN, r.tag, 0, 0, 0, 0);
            end
         end
         OP_OUTCOME: begin
            if (r.ch >= FIRST_CH && r.ch < NUM_CH && ch_owned[r.ch] && ch_busy[r.ch]
                && r.res != RES_IDLE) begin
               ch_busy[r.ch] = 0;
               if (r.res == RES_NAK || r.res == RES_NYET) begin
                  iv = (ch_ivl[r.ch] == 16'd0) ? fallback_ms : ch_ivl[r.ch];
                  ch_due[r.ch] = ms_now + {16'd0, iv};
               end else begin
                  if (r.res == RES_DONE) st = ST_OK;
                  else if (r.res == RES_HALT) st = ST_STALL;
                  else st = ST_IOERR;
                  ch_owned[r.ch] = 0;
                  add_rsp(KIND_DONE, r.ch, st, ch_tag[r.ch], 0, 0, 0,
                          (st == ST_OK && ch_ep[r.ch][7]) ?
                          ((r.cnt < r.room) ? r.cnt : r.room) : 16'd0);
               end
            end
         end
         OP_TICK: begin
            ms_now = ms_now + 32'd1;
            if (port_up)
               for (int c = FIRST_CH; c < NUM_CH; c++) begin
                  diff = ms_now - ch_due[c];   // wrap-safe due test
                  if (ch_owned[c] && !ch_busy[c] && !diff[31]) begin
                     ch_busy[c] = 1;
                     add_rsp(KIND_SUBMIT, 4'(c), ST_OK, ch_tag[c], ch_ep[c], ch_dev[c],
                             0, 0);
                  end
               end
         end
         OP_CONNECT: port_up = 1;
         OP_DISCONNECT: begin
            if (port_up) begin
               port_up = 0;
               for (int c = FIRST_CH; c < NUM_CH; c++) begin
                  if (ch_owned[c]) begin
                     ch_owned[c] = 0;
                     add_rsp(KIND_DONE, 4'(c), ST_RESET, ch_tag[c], 0, 0, 0, 0);
                  end
                  ch_busy[c] = 0; ch_ep[c] = '0; ch_dev[c] = '0; ch_due[c] = '0;
               end
               add_rsp(KIND_REMOVED, 0, ST_OK, 0, 0, 0, 0, 0);
            end
         end
         default: ;   // unknown ops are dropped
      endcase
      if (step_rsps.size() > 0)
         step_rsps[step_rsps.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   task automatic check_rsp();
      rsp_type e;
      if (pending_rsps.size() == 0) begin
         report_mismatch("unexpected response, kind", int'(rsp_kind), -1);
      end else begin
         e = pending_rsps.pop_front();
         if (rsp_kind != e.kind)
            report_mismatch("kind", int'(rsp_kind), int'(e.kind));
         if (rsp_channel_res != e.channel_res)
            report_mismatch("channel_res", int'(rsp_channel_res), int'(e.channel_res));
         if (rsp_status != e.status)
            report_mismatch("status", int'(rsp_status), int'(e.status));
         if (rsp_out_xfer_tag != e.xfer_tag)
            report_mismatch("out_xfer_tag", int'(rsp_out_xfer_tag), int'(e.xfer_tag));
         if (rsp_out_ep_addr != e.ep_addr)
            report_mismatch("out_ep_addr", int'(rsp_out_ep_addr), int'(e.ep_addr));
         if (rsp_out_dev_addr != e.dev_addr)
            report_mismatch("out_dev_addr", int'(rsp_out_dev_addr), int'(e.dev_addr));
         if (rsp_reinit != e.reinit)
            report_mismatch("reinit", int'(rsp_reinit), int'(e.reinit));
         if (rsp_bytes_added != e.bytes_added)
            report_mismatch("bytes_added", int'(rsp_bytes_added), int'(e.bytes_added));
         if (rsp_last != e.last)
            report_mismatch("last", int'(rsp_last), int'(e.last));
      end
   endtask

   // receiver: checks at the edge, then picks ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_rsp();
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // called just after a rising edge; returns just after the accepting edge
   task automatic push_req(sched_req_type r, bit fixed, rsp_type fixed_rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= r.op; req_dev_addr <= r.dev; req_ep_addr <= r.ep;
      req_ep_type <= r.ept; req_poll_interval <= r.ivl; req_xfer_tag <= r.tag;
      req_channel <= r.ch; req_result_code <= r.res;
      req_byte_count <= r.cnt; req_buffer_room <= r.room;
      do @(posedge clock); while (!req_ready);
      sched_predict(r);
      if (fixed)
         pending_rsps.push_back(fixed_rsp);
      else
         foreach (step_rsps[i]) pending_rsps.push_back(step_rsps[i]);
   endtask

   task automatic push_plain(sched_req_type r);
      rsp_type none;
      none = '0;
      push_req(r, 0, none);
   endtask

   // sender pauses until all owed responses are in, then lets the back stage settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_fallback(logic [15:0] v);
      drain();
      csr_write <= 1'b1;
      csr_fallback_interval_ms <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      fallback_ms = v;
   endtask

   function automatic sched_req_type mk_req(logic [2:0] op, logic [6:0] dev, logic [7:0] ep,
                                            logic [1:0] ept, logic [15:0] ivl,
                                            logic [7:0] tag, logic [3:0] ch,
                                            logic [2:0] res,
                                            logic [15:0] cnt, logic [15:0] room);
      sched_req_type r;
      r.op = op; r.dev = dev; r.ep = ep; r.ept = ept; r.ivl = ivl; r.tag = tag;
      r.ch = ch; r.res = res; r.cnt = cnt; r.room = room;
      return r;
   endfunction

   function automatic rsp_type mk_refusal(logic [2:0] st, logic [7:0] tag);
      rsp_type x;
      x = '0;
      x.kind = KIND_DONE; x.status = st; x.xfer_tag = tag; x.last = 1'b1;
      return x;
   endfunction

   // random request: mostly well-formed traffic over a few devices/endpoints
   function automatic sched_req_type rand_req();
      sched_req_type r;
      int            w;
      logic [7:0]    ep_pool [4];
      logic [95:0]   raw;
      ep_pool = '{8'h01, 8'h81, 8'h82, 8'h05};
      raw = {$urandom, $urandom, $urandom};
      r = raw[$bits(sched_req_type)-1:0];
      w = $urandom_range(99);
      if (w < 40) begin
         r.op  = OP_REQUEST;
         if ($urandom_range(3) != 0) r.dev = 7'($urandom_range(2));
         if ($urandom_range(4) != 0) r.ep = ep_pool[$urandom_range(3)];
         if ($urandom_range(9) != 0) r.ept = 2'($urandom_range(3, 2));
         if ($urandom_range(7) != 0) r.ivl = 16'($urandom_range(6));
      end else if (w < 68) begin
         r.op = OP_OUTCOME;
         if ($urandom_range(9) != 0) r.ch = 4'($urandom_range(8, 2));
         if ($urandom_range(9) != 0)
            case ($urandom_range(4))
               0: r.res = RES_DONE;
               1: r.res = RES_NAK;
               2: r.res = RES_NYET;
               3: r.res = RES_HALT;
               default: r.res = RES_ERROR;
            endcase
      end else if (w < 92) begin
         r.op = OP_TICK;
      end else if (w < 96) begin
         r.op = OP_CONNECT;
      end else if (w < 98) begin
         r.op = OP_DISCONNECT;
      end else begin
         r.op = 3'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));   // unknown op
      end
      return r;
   endfunction

   dir_row_type dir_tab[$];

   task automatic add_row(sched_req_type r);
      dir_row_type d;
      d.item = r; d.fixed = 0; d.fixed_rsp = '0;
      dir_tab.push_back(d);
   endtask

   task automatic add_fixed_row(sched_req_type r, rsp_type x);
      dir_row_type d;
      d.item = r; d.fixed = 1; d.fixed_rsp = x;
      dir_tab.push_back(d);
   endtask

   initial begin
      for (int c = 0; c < NUM_CH; c++) begin
         ch_owned[c] = 0; ch_busy[c] = 0; ch_tag[c] = '0; ch_ep[c] = '0;
         ch_dev[c] = '0; ch_ivl[c] = '0; ch_due[c] = '0;
      end
      port_up = 0; ms_now = '0; fallback_ms = FALLBACK_RESET;

      // directed table
      // refused while the port is down, then a disconnect and a repeated connect
      add_fixed_row(mk_req(OP_REQUEST, 7'd5, 8'h01, TYPE_BULK, 0, 8'h11, 0, 0, 0, 0),
                    mk_refusal(ST_RESET, 8'h11));
      add_row(mk_req(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // control endpoints go to the control path; iso/control types unsupported
      add_fixed_row(mk_req(OP_REQUEST, 7'd1, EP_CTRL_OUT, TYPE_BULK, 0, 8'h21, 0, 0, 0, 0),
                    mk_refusal(ST_CTRL, 8'h21));
      add_fixed_row(mk_req(OP_REQUEST, 7'd1, EP_CTRL_IN, TYPE_INTR, 0, 8'h22, 0, 0, 0, 0),
                    mk_refusal(ST_CTRL, 8'h22));
      add_fixed_row(mk_req(OP_REQUEST, 7'd1, 8'h01, TYPE_ISO, 0, 8'h23, 0, 0, 0, 0),
                    mk_refusal(ST_UNSUPP, 8'h23));
      add_fixed_row(mk_req(OP_REQUEST, 7'd1, 8'h01, TYPE_CTRL, 0, 8'h24, 0, 0, 0, 0),
                    mk_refusal(ST_UNSUPP, 8'h24));
      // submits at the field extremes, with a deferral between them
      add_row(mk_req(OP_REQUEST, 7'd127, 8'hFF, TYPE_BULK, 16'd0, 8'hFF, 0, 0, 0, 0));
      add_row(mk_req(OP_REQUEST, 7'd127, 8'hFF, TYPE_BULK, 16'd0, 8'h30, 0, 0, 0, 0));
      add_row(mk_req(OP_REQUEST, 7'd0, 8'h7F, TYPE_INTR, 16'hFFFF, 8'h00, 0, 0, 0, 0));
      // NAK on ch 2 (fallback interval), outcomes that are dropped
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd2, RES_NAK, 0, 0));
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd0, RES_DONE, 0, 0));
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd15, RES_DONE, 0, 0));
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd3, RES_IDLE, 0, 0));
      for (int i = 0; i < 8; i++)
         add_row(mk_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // IN completion clipped to room, stall, unknown outcome code as io error
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd2, RES_DONE, 16'hFFFF, 16'd100));
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd3, RES_HALT, 0, 0));
      add_row(mk_req(OP_REQUEST, 7'd127, 8'hFF, TYPE_BULK, 0, 8'h40, 0, 0, 0, 0));
      add_row(mk_req(OP_OUTCOME, 0, 0, 0, 0, 0, 4'd2, RES_UNKNOWN, 0, 0));
      add_row(mk_req(OP_UNKNOWN_LO, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(OP_UNKNOWN_HI, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(OP_REQUEST, 7'd9, 8'h02, TYPE_INTR, 3, 8'h50, 0, 0, 0, 0));
      add_row(mk_req(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i])
         push_req(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].fixed_rsp);
      drain();

      // long receiver hold-off while every channel is claimed and one more refused
      hold_left = 400;
      push_plain(mk_req(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      for (int i = 0; i < NUM_CH - FIRST_CH + 1; i++)
         push_plain(mk_req(OP_REQUEST, 7'd9, 8'h01 + 8'(i), TYPE_BULK, 0, 8'(i), 0, 0, 0, 0));
      push_plain(mk_req(OP_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      drain();

      // random phases, each setting a fallback and an idling mix
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin set_fallback(16'd1);     send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin set_fallback(16'hFFFF);  send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin set_fallback(16'd0);     send_idle_pct = 0;  recv_stall_pct = 71; end
            3: begin set_fallback(16'($urandom_range(1, 20)));
                     send_idle_pct = 20; recv_stall_pct = 20; end
            default: begin set_fallback(FALLBACK_RESET); send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         push_plain(mk_req(OP_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
         for (int i = 0; i < 12; i++)
            push_plain(rand_req());
      end

      drain();
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
src/hpcs_pkg.sv
src/hpcs_front.sv
src/hpcs_back.sv
src/host_pipe_channel_scheduler.sv
tb/tb_host_pipe_channel_scheduler.sv
